// ===== rtl/backslash_escape_decoder_top_macros.svh =====
// ----------------------------------------------------------------------------
// Backslash escape decoder assertion macros
// Shorthand for the concurrent assertions used by the port checker.
// ----------------------------------------------------------------------------
`ifndef BACKSLASH_ESCAPE_DECODER_TOP_MACROS_SVH
`define BACKSLASH_ESCAPE_DECODER_TOP_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define BED_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define BED_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that is also checked across reset.
`define BED_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/bed_pkg.sv =====
// ----------------------------------------------------------------------------
// Backslash escape decoder package
// Shared types, character codes and small decode functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bed_pkg;

  // Character codes.
  localparam logic [7:0] CHAR_BSL   = 8'h5C;
  localparam logic [7:0] CHAR_R     = 8'h72;
  localparam logic [7:0] CHAR_N     = 8'h6E;
  localparam logic [7:0] CHAR_T     = 8'h74;
  localparam logic [7:0] CHAR_X     = 8'h78;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_EIGHT = 8'h38;
  localparam logic [7:0] CHAR_LA    = 8'h61;
  localparam logic [7:0] CHAR_LF_HEX = 8'h66;
  localparam logic [7:0] CHAR_UA    = 8'h41;
  localparam logic [7:0] CHAR_UF    = 8'h46;
  localparam logic [7:0] CODE_CR    = 8'h0D;
  localparam logic [7:0] CODE_LF    = 8'h0A;
  localparam logic [7:0] CODE_TAB   = 8'h09;
  localparam logic [7:0] HEX_LA_OFS = 8'h57;  // 'a' - 10
  localparam logic [7:0] HEX_UA_OFS = 8'h37;  // 'A' - 10

  // Digit limits for numeric escapes.
  localparam logic [1:0] HEX_MAX = 2'd2;
  localparam logic [1:0] OCT_MAX = 2'd3;

  // Queue between front and back (depth must be a power of two).
  localparam int QDEPTH = 2;
  localparam int QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  typedef enum logic [1:0] {
    PH_PLAIN = 2'd0,
    PH_ESC   = 2'd1,
    PH_HEX   = 2'd2,
    PH_OCT   = 2'd3
  } bed_phase_t;

  // One decoded result beat.
  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       last;
  } bed_res_t;

  // One queue entry: the one or two results caused by an input beat.
  typedef struct packed {
    logic     two;
    bed_res_t r0;
    bed_res_t r1;
  } bed_entry_t;

  typedef struct packed {
    logic     emit;
    logic     to_esc;
    bed_res_t res;
  } bed_plain_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } bed_hex_t;

  // Plain-text handling of one byte.
  function automatic bed_plain_t plain_byte(logic [7:0] b, logic last);
    bed_plain_t p;
    p.emit     = 1'b1;
    p.to_esc   = 1'b0;
    p.res.data = b;
    p.res.has  = 1'b1;
    p.res.last = last;
    if (b == CHAR_BSL) begin
      if (last) begin
        // A trailing backslash becomes a bare end marker.
        p.res.data = 8'h00;
        p.res.has  = 1'b0;
      end else begin
        p.emit   = 1'b0;
        p.to_esc = 1'b1;
      end
    end
    return p;
  endfunction

  // Hex digit decode.
  function automatic bed_hex_t hex_digit(logic [7:0] b);
    bed_hex_t   h;
    logic [7:0] t;
    h.ok = 1'b0;
    t    = 8'h00;
    if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
      h.ok = 1'b1;
      t    = b - CHAR_ZERO;
    end else if (b >= CHAR_LA && b <= CHAR_LF_HEX) begin
      h.ok = 1'b1;
      t    = b - HEX_LA_OFS;
    end else if (b >= CHAR_UA && b <= CHAR_UF) begin
      h.ok = 1'b1;
      t    = b - HEX_UA_OFS;
    end
    h.val = t[3:0];
    return h;
  endfunction

  function automatic logic is_octal(logic [7:0] b);
    return (b >= CHAR_ZERO) && (b < CHAR_EIGHT);
  endfunction

endpackage

// ===== rtl/bed_front.sv =====
// ----------------------------------------------------------------------------
// Backslash escape decoder front end
// Accepts input beats, tracks escape state and packs results into entries.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bed_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [7:0]          in_byte,
  input  logic                in_last,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                q_full,
  output logic                push,
  output bed_pkg::bed_entry_t push_entry
);

  bed_pkg::bed_phase_t phase_r, phase_nxt;
  logic [1:0]          cnt_r, cnt_nxt;
  logic [7:0]          acc_r, acc_nxt;

  logic                accept;
  logic                emit;
  bed_pkg::bed_plain_t pl;
  bed_pkg::bed_hex_t   hx;
  logic [1:0]          cnt_inc;
  logic [7:0]          acc_hex;
  logic [7:0]          acc_oct;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && emit;

  assign pl      = bed_pkg::plain_byte(in_byte, in_last);
  assign hx      = bed_pkg::hex_digit(in_byte);
  assign cnt_inc = cnt_r + 2'd1;
  assign acc_hex = {acc_r[3:0], hx.val};
  assign acc_oct = {acc_r[4:0], in_byte[2:0]};

  // Escape state machine: next state and the entry for this beat.
  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    acc_nxt    = acc_r;
    emit       = 1'b0;
    push_entry = '0;
    case (phase_r)
      bed_pkg::PH_PLAIN: begin
        emit          = pl.emit;
        push_entry.r0 = pl.res;
        phase_nxt     = pl.to_esc ? bed_pkg::PH_ESC : bed_pkg::PH_PLAIN;
        cnt_nxt       = 2'd0;
        acc_nxt       = 8'h00;
      end
      bed_pkg::PH_ESC: begin
        phase_nxt = bed_pkg::PH_PLAIN;
        cnt_nxt   = 2'd0;
        acc_nxt   = 8'h00;
        emit      = 1'b1;
        push_entry.r0 = '{data: in_byte, has: 1'b1, last: in_last};
        if (in_byte == bed_pkg::CHAR_R) begin
          push_entry.r0.data = bed_pkg::CODE_CR;
        end else if (in_byte == bed_pkg::CHAR_N) begin
          push_entry.r0.data = bed_pkg::CODE_LF;
        end else if (in_byte == bed_pkg::CHAR_T) begin
          push_entry.r0.data = bed_pkg::CODE_TAB;
        end else if (in_byte == bed_pkg::CHAR_X) begin
          // "\x" at the end of a string yields zero.
          push_entry.r0.data = 8'h00;
          if (!in_last) begin
            emit      = 1'b0;
            phase_nxt = bed_pkg::PH_HEX;
          end
        end else if (bed_pkg::is_octal(in_byte)) begin
          push_entry.r0.data = {5'd0, in_byte[2:0]};
          if (!in_last) begin
            emit      = 1'b0;
            phase_nxt = bed_pkg::PH_OCT;
            cnt_nxt   = 2'd1;
            acc_nxt   = {5'd0, in_byte[2:0]};
          end
        end
      end
      bed_pkg::PH_HEX: begin
        if (hx.ok && cnt_r < bed_pkg::HEX_MAX) begin
          if (cnt_inc >= bed_pkg::HEX_MAX || in_last) begin
            emit          = 1'b1;
            push_entry.r0 = '{data: acc_hex, has: 1'b1, last: in_last};
            phase_nxt     = bed_pkg::PH_PLAIN;
            cnt_nxt       = 2'd0;
            acc_nxt       = 8'h00;
          end else begin
            cnt_nxt = cnt_inc;
            acc_nxt = acc_hex;
          end
        end else begin
          // Run ended by another byte: number first, then the byte as text.
          emit           = 1'b1;
          push_entry.r0  = '{data: acc_r, has: 1'b1, last: 1'b0};
          push_entry.two = pl.emit;
          push_entry.r1  = pl.res;
          phase_nxt      = pl.to_esc ? bed_pkg::PH_ESC : bed_pkg::PH_PLAIN;
          cnt_nxt        = 2'd0;
          acc_nxt        = 8'h00;
        end
      end
      bed_pkg::PH_OCT: begin
        if (bed_pkg::is_octal(in_byte) && cnt_r < bed_pkg::OCT_MAX) begin
          if (cnt_inc >= bed_pkg::OCT_MAX || in_last) begin
            emit          = 1'b1;
            push_entry.r0 = '{data: acc_oct, has: 1'b1, last: in_last};
            phase_nxt     = bed_pkg::PH_PLAIN;
            cnt_nxt       = 2'd0;
            acc_nxt       = 8'h00;
          end else begin
            cnt_nxt = cnt_inc;
            acc_nxt = acc_oct;
          end
        end else begin
          emit           = 1'b1;
          push_entry.r0  = '{data: acc_r, has: 1'b1, last: 1'b0};
          push_entry.two = pl.emit;
          push_entry.r1  = pl.res;
          phase_nxt      = pl.to_esc ? bed_pkg::PH_ESC : bed_pkg::PH_PLAIN;
          cnt_nxt        = 2'd0;
          acc_nxt        = 8'h00;
        end
      end
      default: begin
        phase_nxt = bed_pkg::PH_PLAIN;
        cnt_nxt   = 2'd0;
        acc_nxt   = 8'h00;
      end
    endcase
    // The end of a string always returns to plain text.
    if (in_last) begin
      phase_nxt = bed_pkg::PH_PLAIN;
      cnt_nxt   = 2'd0;
      acc_nxt   = 8'h00;
    end
  end

  // State registers advance only on an accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= bed_pkg::PH_PLAIN;
      cnt_r   <= 2'd0;
      acc_r   <= 8'h00;
    end else if (accept) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      acc_r   <= acc_nxt;
    end
  end

endmodule

// ===== rtl/bed_queue.sv =====
// ----------------------------------------------------------------------------
// Backslash escape decoder entry queue
// Small FIFO of result entries between the front and back ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bed_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  bed_pkg::bed_entry_t push_entry,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output bed_pkg::bed_entry_t head_entry
);

  bed_pkg::bed_entry_t         store_r [bed_pkg::QDEPTH];
  logic [bed_pkg::QAW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [bed_pkg::QAW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [bed_pkg::QAW:0]       count_r, count_nxt;
  logic                        do_push;
  logic                        do_pop;

  assign full       = (count_r == (bed_pkg::QAW+1)'(bed_pkg::QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_entry = store_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ===== rtl/bed_back.sv =====
// ----------------------------------------------------------------------------
// Backslash escape decoder back end
// Unpacks queue entries into single result beats held in an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bed_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                head_valid,
  input  bed_pkg::bed_entry_t head_entry,
  output logic                pop,
  output logic [7:0]          out_byte,
  output logic                out_has_byte,
  output logic                out_last,
  output logic                out_valid,
  input  logic                out_ready
);

  logic             out_valid_r, out_valid_nxt;
  logic             sel_r, sel_nxt;
  bed_pkg::bed_res_t res_r;
  bed_pkg::bed_res_t pick;
  logic             load;

  assign load = head_valid && (!out_valid_r || out_ready);
  assign pick = sel_r ? head_entry.r1 : head_entry.r0;

  // Pop the head once its final result goes into the output register.
  always_comb begin
    sel_nxt       = sel_r;
    pop           = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    if (load) begin
      out_valid_nxt = 1'b1;
      if (head_entry.two && !sel_r) begin
        sel_nxt = 1'b1;
      end else begin
        sel_nxt = 1'b0;
        pop     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sel_r       <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sel_r       <= sel_nxt;
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= pick;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_byte     = res_r.data;
  assign out_has_byte = res_r.has;
  assign out_last     = res_r.last;

endmodule

// ===== rtl/backslash_escape_decoder_top.sv =====
// ----------------------------------------------------------------------------
// Backslash escape decoder top level
// A result beat passes through the entry queue and the output register.
// Throughput: one input beat per cycle while the queue is not full; an input
//   beat that closes a numeric escape and carries a text byte yields two beats.
// Rate is set by the output register: one result beat per cycle while ready.
// Reset: synchronous, active low; escape state and queue are cleared at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module backslash_escape_decoder_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       in_valid,
  output logic       in_ready,
  output logic [7:0] out_byte,
  output logic       out_has_byte,
  output logic       out_last,
  output logic       out_valid,
  input  logic       out_ready
);

  logic                push;
  bed_pkg::bed_entry_t push_entry;
  logic                q_full;
  logic                pop;
  logic                head_valid;
  bed_pkg::bed_entry_t head_entry;

  // Front end: escape decoding.
  bed_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_byte    (in_byte),
    .in_last    (in_last),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // Entry queue.
  bed_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  // Back end: result beats.
  bed_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_valid   (head_valid),
    .head_entry   (head_entry),
    .pop          (pop),
    .out_byte     (out_byte),
    .out_has_byte (out_has_byte),
    .out_last     (out_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready)
  );

endmodule

// ===== rtl/bed_checker.sv =====
// ----------------------------------------------------------------------------
// Backslash escape decoder port checker
// Watches the top-level ports and flags illegal result beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "backslash_escape_decoder_top_macros.svh"

module bed_checker (
  input logic       clk,
  input logic       rst_n,
  input logic [7:0] in_byte,
  input logic       in_last,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] out_byte,
  input logic       out_has_byte,
  input logic       out_last,
  input logic       out_valid,
  input logic       out_ready
);

  // A stalled input beat stays offered with its payload intact.
  `BED_ASSERT_NXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(in_byte) && $stable(in_last), "stalled input beat changed")

  // A stalled result beat stays valid with its payload intact.
  `BED_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(out_has_byte) && $stable(out_last), "stalled result beat changed")

  // A beat without data is only ever the end marker of a string.
  `BED_ASSERT_IMP(a_bare_is_last, out_valid && !out_has_byte, out_last, "bare beat without last")

  // A beat without data carries a zero byte.
  `BED_ASSERT_IMP(a_bare_zero, out_valid && !out_has_byte, out_byte == 8'h00, "bare beat with data")

  // No result beat right after reset.
  `BED_ASSERT_RST(a_reset_quiet, !rst_n, !out_valid, "result beat after reset")

endmodule

bind backslash_escape_decoder_top bed_checker u_bed_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_byte      (in_byte),
  .in_last      (in_last),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_byte     (out_byte),
  .out_has_byte (out_has_byte),
  .out_last     (out_last),
  .out_valid    (out_valid),
  .out_ready    (out_ready)
);

// ===== verif/backslash_escape_decoder_top_tb.sv =====
// ----------------------------------------------------------------------------
// Backslash escape decoder testbench
// Drives escaped text into the decoder with random gaps on both channels and
// compares every decoded beat with a predictor that tracks the escape state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module backslash_escape_decoder_top_tb;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int LONG_HOLD    = 400;
  localparam int PHASE_ITEMS  = 350;
  localparam int SHOWN_ERRORS = 10;

  // Scoreboard: predicts decoded beats and checks them in order.
  class escape_scoreboard;
    bed_pkg::bed_res_t   decoded_q[$];
    int                  mismatches;
    bed_pkg::bed_phase_t ph;
    logic [1:0]          digits;
    logic [7:0]          acc;

    function new();
      mismatches = 0;
      clear_escape();
    endfunction

    function void clear_escape();
      ph     = bed_pkg::PH_PLAIN;
      digits = 2'd0;
      acc    = 8'h00;
    endfunction

    function void push_beat(logic [7:0] d, logic h, logic l);
      bed_pkg::bed_res_t r;
      r.data = h ? d : 8'h00;
      r.has  = h;
      r.last = l;
      decoded_q.push_back(r);
    endfunction

    function int hex_nibble(logic [7:0] c);
      if (c >= bed_pkg::CHAR_ZERO && c <= bed_pkg::CHAR_NINE)
        return int'(c) - int'(bed_pkg::CHAR_ZERO);
      if (c >= bed_pkg::CHAR_LA && c <= bed_pkg::CHAR_LF_HEX)
        return int'(c) - int'(bed_pkg::CHAR_LA) + 10;
      if (c >= bed_pkg::CHAR_UA && c <= bed_pkg::CHAR_UF)
        return int'(c) - int'(bed_pkg::CHAR_UA) + 10;
      return -1;
    endfunction

    function logic octal_char(logic [7:0] c);
      return (c >= bed_pkg::CHAR_ZERO) && (c < bed_pkg::CHAR_EIGHT);
    endfunction

    // A byte seen outside any escape.
    function void text_byte(logic [7:0] c, logic l);
      clear_escape();
      if (c == bed_pkg::CHAR_BSL) begin
        if (l) push_beat(8'h00, 1'b0, 1'b1);
        else ph = bed_pkg::PH_ESC;
      end else begin
        push_beat(c, 1'b1, l);
      end
    endfunction

    // Called for every accepted input beat.
    function void note_input(logic [7:0] c, logic l);
      int nib;
      case (ph)
        bed_pkg::PH_PLAIN: text_byte(c, l);
        bed_pkg::PH_ESC: begin
          clear_escape();
          if (c == bed_pkg::CHAR_R) push_beat(bed_pkg::CODE_CR, 1'b1, l);
          else if (c == bed_pkg::CHAR_N) push_beat(bed_pkg::CODE_LF, 1'b1, l);
          else if (c == bed_pkg::CHAR_T) push_beat(bed_pkg::CODE_TAB, 1'b1, l);
          else if (c == bed_pkg::CHAR_X) begin
            if (l) push_beat(8'h00, 1'b1, 1'b1);
            else ph = bed_pkg::PH_HEX;
          end else if (octal_char(c)) begin
            if (l) push_beat(c - bed_pkg::CHAR_ZERO, 1'b1, 1'b1);
            else begin
              ph     = bed_pkg::PH_OCT;
              digits = 2'd1;
              acc    = c - bed_pkg::CHAR_ZERO;
            end
          end else begin
            push_beat(c, 1'b1, l);
          end
        end
        bed_pkg::PH_HEX: begin
          nib = hex_nibble(c);
          if (nib >= 0 && digits < bed_pkg::HEX_MAX) begin
            acc    = {acc[3:0], nib[3:0]};
            digits = digits + 2'd1;
            if (digits >= bed_pkg::HEX_MAX || l) begin
              push_beat(acc, 1'b1, l);
              clear_escape();
            end
          end else begin
            // The number ends here and the byte is handled as text.
            push_beat(acc, 1'b1, 1'b0);
            text_byte(c, l);
          end
        end
        default: begin
          if (octal_char(c) && digits < bed_pkg::OCT_MAX) begin
            acc    = {acc[4:0], c[2:0]};
            digits = digits + 2'd1;
            if (digits >= bed_pkg::OCT_MAX || l) begin
              push_beat(acc, 1'b1, l);
              clear_escape();
            end
          end else begin
            push_beat(acc, 1'b1, 1'b0);
            text_byte(c, l);
          end
        end
      endcase
      if (l) clear_escape();
    endfunction

    // Called for every accepted result beat.
    function void check_result(logic [7:0] d, logic h, logic l);
      bed_pkg::bed_res_t want;
      if (decoded_q.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_ERRORS)
          $display("unexpected beat: byte %02h has %0b last %0b", d, h, l);
        return;
      end
      want = decoded_q.pop_front();
      if (want.data !== d || want.has !== h || want.last !== l) begin
        mismatches++;
        if (mismatches <= SHOWN_ERRORS)
          $display("beat differs: expected byte %02h has %0b last %0b, got %02h %0b %0b",
                   want.data, want.has, want.last, d, h, l);
      end
    endfunction

    function int pending();
      return decoded_q.size();
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic [7:0] in_byte;
  logic       in_last;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] out_byte;
  logic       out_has_byte;
  logic       out_last;
  logic       out_valid;
  logic       out_ready;

  escape_scoreboard sb = new();

  int send_idle_pct;
  int recv_idle_pct;
  int hold_asked;
  int hold_seen;
  int hold_left;
  int items_sent;
  int cycles;

  backslash_escape_decoder_top u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_byte      (in_byte),
    .in_last      (in_last),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_byte     (out_byte),
    .out_has_byte (out_has_byte),
    .out_last     (out_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready)
  );

  // Clock.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Cycle counter and timeout.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("backslash_escape_decoder_top: mismatch");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_seen != hold_asked) begin
      hold_seen = hold_asked;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: every beat on either channel goes to the scoreboard.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_input(in_byte, in_last);
      if (out_valid && out_ready) sb.check_result(out_byte, out_has_byte, out_last);
    end
  end

  // Offer one beat and wait until it is accepted; valid stays high between
  // back-to-back beats.
  task automatic send_beat(input logic [7:0] b, input logic l);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_byte  <= b;
    in_last  <= l;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // Send a string with the last mark on its final byte.
  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(s[i], i == s.len() - 1);
  endtask

  // Stop offering beats until every predicted beat has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One random string built from plain bytes, escapes, noise and lone backslashes.
  task automatic send_random_string();
    logic [7:0] text_q[$];
    string      hex_chars;
    string      near_chars;
    int         ntok;
    int         n;
    hex_chars  = "0123456789abcdefABCDEF";
    near_chars = "0123456789abcdefxXrnt8";
    ntok = $urandom_range(12, 1);
    for (int t = 0; t < ntok; t++) begin
      case ($urandom_range(9))
        0, 1, 2: begin
          n = $urandom_range(255);
          text_q.push_back(n == bed_pkg::CHAR_BSL ? bed_pkg::CHAR_LA : n[7:0]);
        end
        3: begin
          text_q.push_back(bed_pkg::CHAR_BSL);
          case ($urandom_range(2))
            0: text_q.push_back(bed_pkg::CHAR_R);
            1: text_q.push_back(bed_pkg::CHAR_N);
            default: text_q.push_back(bed_pkg::CHAR_T);
          endcase
        end
        4: begin
          text_q.push_back(bed_pkg::CHAR_BSL);
          text_q.push_back(bed_pkg::CHAR_X);
          n = $urandom_range(3);
          for (int k = 0; k < n; k++)
            text_q.push_back(hex_chars[$urandom_range(hex_chars.len() - 1)]);
        end
        5: begin
          text_q.push_back(bed_pkg::CHAR_BSL);
          n = $urandom_range(4, 1);
          for (int k = 0; k < n; k++)
            text_q.push_back(bed_pkg::CHAR_ZERO + 8'($urandom_range(7)));
        end
        6: begin
          text_q.push_back(bed_pkg::CHAR_BSL);
          text_q.push_back(8'($urandom_range(255)));
        end
        7: begin
          // Noise: any byte, backslash included.
          n = $urandom_range(3, 1);
          for (int k = 0; k < n; k++) text_q.push_back(8'($urandom_range(255)));
        end
        8: text_q.push_back(bed_pkg::CHAR_BSL);
        default: text_q.push_back(near_chars[$urandom_range(near_chars.len() - 1)]);
      endcase
    end
    for (int i = 0; i < text_q.size(); i++) send_beat(text_q[i], i == text_q.size() - 1);
  endtask

  // Main sequence.
  initial begin
    rst_n         = 1'b0;
    in_byte       = 8'h00;
    in_last       = 1'b0;
    in_valid      = 1'b0;
    out_ready     = 1'b0;
    send_idle_pct = 6;
    recv_idle_pct = 65;
    hold_asked    = 0;
    hold_seen     = 0;
    hold_left     = 0;
    items_sent    = 0;
    cycles        = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: byte extremes, each escape and the edge cases.
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b1);
    send_text("\\r\\n\\t");
    send_text("\\x4F");
    send_text("\\xG");       // no hex digit, run ended by text
    send_text("\\x");        // escape cut off by the end mark
    send_text("\\777\\12z"); // full octal with overflow, then a short run
    send_text("\\5");        // partial octal at the end
    send_text("\\");         // lone trailing backslash
    send_text("\\\\");
    wait_drained();

    // Random, sender rarely idle and receiver often stalled. The long hold-off
    // lets the decoder fill up while beats keep coming.
    hold_asked++;
    while (items_sent < PHASE_ITEMS) send_random_string();
    wait_drained();

    // Random, roles swapped.
    send_idle_pct = 65;
    recv_idle_pct = 6;
    while (items_sent < 2 * PHASE_ITEMS) send_random_string();
    wait_drained();

    // Random, no idling at all.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (items_sent < 3 * PHASE_ITEMS) send_random_string();
    wait_drained();
    repeat (20) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("backslash_escape_decoder_top: match");
    end else begin
      $display("backslash_escape_decoder_top: mismatch");
    end
    $finish;
  end

endmodule

// ===== backslash_escape_decoder_top.f =====
+incdir+rtl
rtl/bed_pkg.sv
rtl/bed_front.sv
rtl/bed_queue.sv
rtl/bed_back.sv
rtl/backslash_escape_decoder_top.sv
rtl/bed_checker.sv
verif/backslash_escape_decoder_top_tb.sv
